FILE: sv/memt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiturn tracker package
// Shared widths, constants, register indexes and item types.
// ----------------------------------------------------------------------------
package memt_pkg;

    localparam int SLOTS      = 5;
    localparam int ACC_BITS   = 40;

    localparam int ID_W       = 11;
    localparam int ANG_W      = 13;
    localparam int SPD_W      = 16;
    localparam int CUR_W      = 16;
    localparam int DEG_W      = 48;
    localparam int SLOT_W     = 3;
    localparam int WLIM_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [ID_W-1:0]   RST_CHASSIS_FIRST = 11'd513;
    localparam logic [ID_W-1:0]   RST_AUX_ID        = 11'd517;
    localparam logic [WLIM_W-1:0] RST_WRAP_LIMIT    = 13'd1250;

    localparam logic [ANG_W-1:0]  ENC_SPAN = 13'd8191;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Degrees conversion: out = floor((2*c*N + D) / (2*D)) with
    // N = 150*D - 22070, which gives out = 150*|c| - floor(z / (2*D)),
    // z = 44140*|c| + D - 1, and the sign applied afterwards.
    localparam longint DEG_DEN   = 3268209;
    localparam longint DEG_DEN2  = 2 * DEG_DEN;
    localparam int     D2_W      = 23;
    localparam int     TRIM_W    = 16;
    localparam logic [TRIM_W-1:0] DEG_TRIM = 16'd44140;
    localparam int     SCALE_W   = 8;
    localparam logic [SCALE_W-1:0] DEG_SCALE = 8'd150;

    localparam int Z_W     = ACC_BITS + TRIM_W;
    localparam int D_SHIFT = 22;
    localparam int ZH_W    = Z_W - D_SHIFT;
    localparam int ZL_HALF = ZH_W / 2;
    localparam int PROD_W  = 2 * ZH_W;
    localparam int R_W     = D2_W + 2;
    localparam int RES_W   = ACC_BITS + SCALE_W;
    localparam int SAT_W   = (RES_W > DEG_W + 1) ? RES_W : DEG_W + 1;

    localparam logic [127:0]      RECIP_WIDE = (128'd1 << Z_W) / 128'(DEG_DEN2);
    localparam logic [ZH_W-1:0]   RECIP      = RECIP_WIDE[ZH_W-1:0];
    localparam logic [D2_W-1:0]   K_D2       = D2_W'(DEG_DEN2);
    localparam logic [Z_W-1:0]    Z_BIAS     = Z_W'(DEG_DEN - 1);
    localparam logic [R_W-1:0]    R_ONE_D2   = R_W'(DEG_DEN2);
    localparam logic [R_W-1:0]    R_TWO_D2   = R_W'(2 * DEG_DEN2);
    localparam logic [SAT_W-1:0]  SAT_NEG_LIM = SAT_W'(1) << (DEG_W - 1);
    localparam logic [SAT_W-1:0]  SAT_POS_LIM = SAT_NEG_LIM - SAT_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHASSIS_FIRST = 2'd0,
        CFG_AUX_ID        = 2'd1,
        CFG_WRAP_LIMIT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                     matched;
        logic [SLOT_W-1:0]        slot;
        logic [ANG_W-1:0]         angle;
        logic signed [SPD_W-1:0]  speed;
        logic signed [CUR_W-1:0]  current;
    } t_item;

endpackage

`default_nettype wire

FILE: sv/memt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiturn tracker front end
// Holds the configuration registers and maps each frame ID to a motor slot.
// ----------------------------------------------------------------------------
module memt_front
    import memt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  wire logic [ID_W-1:0]         i_frame_id,
    input  wire logic [ANG_W-1:0]        i_angle,
    input  wire logic signed [SPD_W-1:0] i_speed,
    input  wire logic signed [CUR_W-1:0] i_current,
    output t_item                        o_item,
    output logic [WLIM_W-1:0]            o_wrap_limit
);

    logic [ID_W-1:0]   r_chassis_first;
    logic [ID_W-1:0]   r_aux_id;
    logic [WLIM_W-1:0] r_wrap_limit;

    logic [ID_W-1:0]   id_off;
    logic              chassis_hit;
    logic              aux_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chassis_first <= RST_CHASSIS_FIRST;
            r_aux_id        <= RST_AUX_ID;
            r_wrap_limit    <= RST_WRAP_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CHASSIS_FIRST: r_chassis_first <= i_cfg_wr_data[ID_W-1:0];
                CFG_AUX_ID:        r_aux_id        <= i_cfg_wr_data[ID_W-1:0];
                CFG_WRAP_LIMIT:    r_wrap_limit    <= i_cfg_wr_data[WLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign id_off      = i_frame_id - r_chassis_first;
    assign chassis_hit = (i_frame_id >= r_chassis_first) && (id_off < ID_W'(SLOTS - 1));
    assign aux_hit     = (i_frame_id == r_aux_id);

    // A chassis match takes precedence when both IDs coincide.
    always_comb begin
        o_item = '0;
        priority if (chassis_hit) begin
            o_item.matched = 1'b1;
            o_item.slot    = SLOT_W'(id_off);
        end else if (aux_hit) begin
            o_item.matched = 1'b1;
            o_item.slot    = SLOT_W'(SLOTS - 1);
        end else begin
            o_item.matched = 1'b0;
        end
        if (o_item.matched) begin
            o_item.angle   = i_angle;
            o_item.speed   = i_speed;
            o_item.current = i_current;
        end
    end

    assign o_wrap_limit = r_wrap_limit;

endmodule

`default_nettype wire

FILE: sv/memt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiturn tracker item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module memt_queue
    import memt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_data
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic push_ok;
    logic pop_ok;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/memt_slots.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiturn tracker slot state
// Per-slot angle history and count accumulator, updated once per item.
// ----------------------------------------------------------------------------
module memt_slots
    import memt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  t_item                      i_item,
    input  wire logic [WLIM_W-1:0]     i_wrap_limit,
    output logic                       o_valid,
    output t_item                      o_item,
    output logic signed [ACC_BITS-1:0] o_count
);

    logic [ANG_W-1:0]         r_prev  [SLOTS];
    logic                     r_seen  [SLOTS];
    logic signed [ACC_BITS-1:0] r_total [SLOTS];
    logic                     r_vld;
    t_item                    r_item;
    logic signed [ACC_BITS-1:0] r_count;

    logic [SLOT_W-1:0]          sidx;
    logic [ANG_W-1:0]           prev;
    logic                       seen;
    logic signed [ACC_BITS-1:0] total;
    logic signed [ANG_W+1:0]    diff;
    logic [ANG_W-1:0]           wrap_fwd;
    logic [ANG_W-1:0]           wrap_rev;
    logic signed [ANG_W+1:0]    delta;
    logic signed [ACC_BITS:0]   sum;
    logic signed [ACC_BITS-1:0] sat;
    logic signed [ACC_BITS-1:0] n_total;
    logic                       update;

    assign sidx  = i_item.slot;
    assign prev  = r_prev[sidx];
    assign seen  = r_seen[sidx];
    assign total = r_total[sidx];

    assign diff     = $signed({2'b00, i_item.angle}) - $signed({2'b00, prev});
    assign wrap_fwd = ENC_SPAN + i_item.angle - prev;
    assign wrap_rev = ENC_SPAN + prev - i_item.angle;

    // Forward motion only counts positive steps and reverse motion only
    // negative ones; a wrap step at or beyond the limit is treated as noise.
    always_comb begin
        delta = '0;
        if (!i_item.speed[SPD_W-1]) begin
            if (i_item.angle < prev) begin
                if (wrap_fwd < i_wrap_limit) begin
                    delta = $signed({2'b00, wrap_fwd});
                end
            end else begin
                delta = diff;
            end
        end else begin
            if (i_item.angle > prev) begin
                if (wrap_rev < i_wrap_limit) begin
                    delta = -$signed({2'b00, wrap_rev});
                end
            end else begin
                delta = diff;
            end
        end
    end

    assign sum = $signed({total[ACC_BITS-1], total}) + (ACC_BITS + 1)'(delta);

    always_comb begin
        if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
            sat = sum[ACC_BITS] ? {1'b1, {(ACC_BITS - 1){1'b0}}}
                                : {1'b0, {(ACC_BITS - 1){1'b1}}};
        end else begin
            sat = sum[ACC_BITS-1:0];
        end
    end

    assign n_total = seen ? sat : total;
    assign update  = i_en && i_valid && i_item.matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_seen[i]  <= 1'b0;
                r_total[i] <= '0;
            end
        end else begin
            if (i_en) begin
                r_vld <= i_valid;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (update && (sidx == SLOT_W'(i))) begin
                    r_seen[i]  <= 1'b1;
                    r_total[i] <= n_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (update && (sidx == SLOT_W'(i))) begin
                r_prev[i] <= i_item.angle;
            end
        end
        if (i_en) begin
            r_item  <= i_item;
            r_count <= i_item.matched ? n_total : '0;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: sv/memt_degconv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiturn tracker degrees converter
// Pipelined conversion of a count total to output degrees in signed Q32.16.
// ----------------------------------------------------------------------------
module memt_degconv
    import memt_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  t_item                            i_item,
    input  wire logic signed [ACC_BITS-1:0]  i_count,
    output logic                             o_valid,
    output t_item                            o_item,
    output logic signed [DEG_W-1:0]          o_degrees
);

    localparam int NSTG = 7;

    logic  r_vld  [NSTG];
    t_item r_item [NSTG];

    logic                      r_neg1, r_neg2, r_neg3, r_neg4, r_neg5, r_neg6;
    logic [ACC_BITS-1:0]       r_mag1, r_mag2, r_mag3, r_mag4, r_mag5;
    logic [Z_W-1:0]            r_z2, r_z3, r_z4;
    logic [ZL_HALF+ZH_W-1:0]   r_pp_lo3;
    logic [PROD_W-ZL_HALF-1:0] r_pp_hi3;
    logic [ZH_W-1:0]           r_qest4, r_qest5;
    logic [R_W-1:0]            r_rem5;
    logic [RES_W-1:0]          r_res6;
    logic signed [DEG_W-1:0]   r_deg7;

    logic [ZH_W-1:0]           zh;
    logic [PROD_W-1:0]         prod;
    logic [ZH_W+D2_W-1:0]      qd;
    logic [Z_W-1:0]            rem_full;
    logic [1:0]                corr;
    logic [SAT_W-1:0]          res_x;
    logic [SAT_W-1:0]          res_c;

    assign zh       = r_z2[Z_W-1:D_SHIFT];
    assign prod     = {r_pp_hi3, {ZL_HALF{1'b0}}} + PROD_W'(r_pp_lo3);
    assign qd       = r_qest4 * K_D2;
    assign rem_full = r_z4 - qd[Z_W-1:0];
    assign corr     = {1'b0, (r_rem5 >= R_ONE_D2)} + {1'b0, (r_rem5 >= R_TWO_D2)};
    assign res_x    = SAT_W'(r_res6);

    always_comb begin
        if (r_neg6) begin
            res_c = (res_x > SAT_NEG_LIM) ? SAT_NEG_LIM : res_x;
        end else begin
            res_c = (res_x > SAT_POS_LIM) ? SAT_POS_LIM : res_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int k = 1; k < NSTG; k++) begin
                r_item[k] <= r_item[k-1];
            end

            // Magnitude and sign.
            r_neg1 <= i_count[ACC_BITS-1];
            r_mag1 <= i_count[ACC_BITS-1] ? ACC_BITS'(0) - ACC_BITS'(i_count)
                                          : ACC_BITS'(i_count);

            // Numerator of the correction term.
            r_z2   <= Z_W'(r_mag1) * Z_W'(DEG_TRIM) + Z_BIAS;
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;

            // Reciprocal multiply in two partial products.
            r_pp_lo3 <= (ZL_HALF + ZH_W)'(zh[ZL_HALF-1:0]) * (ZL_HALF + ZH_W)'(RECIP);
            r_pp_hi3 <= (PROD_W - ZL_HALF)'(zh[ZH_W-1:ZL_HALF])
                        * (PROD_W - ZL_HALF)'(RECIP);
            r_z3     <= r_z2;
            r_mag3   <= r_mag2;
            r_neg3   <= r_neg2;

            // Quotient estimate, at most two below the true quotient.
            r_qest4 <= prod[PROD_W-1:ZH_W];
            r_z4    <= r_z3;
            r_mag4  <= r_mag3;
            r_neg4  <= r_neg3;

            r_rem5  <= rem_full[R_W-1:0];
            r_qest5 <= r_qest4;
            r_mag5  <= r_mag4;
            r_neg5  <= r_neg4;

            r_res6  <= RES_W'(r_mag5) * RES_W'(DEG_SCALE) - RES_W'(r_qest5) - RES_W'(corr);
            r_neg6  <= r_neg5;

            r_deg7  <= r_neg6 ? DEG_W'(SAT_W'(0) - res_c) : DEG_W'(res_c);
        end
    end

    assign o_valid   = r_vld[NSTG-1];
    assign o_item    = r_item[NSTG-1];
    assign o_degrees = r_deg7;

endmodule

`default_nettype wire

FILE: sv/motor_encoder_multiturn_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A frame passes through the queue, the slot update register and seven conversion
// stages before its result appears; throughput is one frame per cycle while the
// output is not stalled, set by the read-modify-write of the slot state.
// Input ready depends only on the four-entry queue, not on output ready.
// Synchronous active-low reset clears the configuration to its defaults, all
// slot totals and seen flags, the queue and the pipeline valid bits.
// ----------------------------------------------------------------------------
// Motor encoder multiturn tracker
// Unwraps rotor angles per motor slot and reports output shaft degrees.
// ----------------------------------------------------------------------------
module motor_encoder_multiturn_tracker_core
    import memt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // rotor_angle[12:0], rotor_speed[28:13], torque_current[44:29], zero pad
    input  wire logic [47:0]           s_axis_tdata,
    // frame_id[10:0]
    input  wire logic [ID_W-1:0]       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // angle_echo[12:0], speed_echo[28:13], current_echo[44:29],
    // output_degrees[92:45], zero pad
    output logic [95:0]                m_axis_tdata,
    // matched[0], slot[3:1]
    output logic [3:0]                 m_axis_tuser
);

    t_item                      front_item;
    logic [WLIM_W-1:0]          wrap_limit;
    logic                       q_full;
    logic                       q_valid;
    t_item                      q_item;
    logic                       en;
    logic                       slot_valid;
    t_item                      slot_item;
    logic signed [ACC_BITS-1:0] slot_count;
    logic                       out_valid;
    t_item                      out_item;
    logic signed [DEG_W-1:0]    out_degrees;

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = !q_full;

    memt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_frame_id    (s_axis_tuser),
        .i_angle       (s_axis_tdata[12:0]),
        .i_speed       (s_axis_tdata[28:13]),
        .i_current     (s_axis_tdata[44:29]),
        .o_item        (front_item),
        .o_wrap_limit  (wrap_limit)
    );

    memt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (en),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    memt_slots u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .i_wrap_limit (wrap_limit),
        .o_valid      (slot_valid),
        .o_item       (slot_item),
        .o_count      (slot_count)
    );

    memt_degconv u_degconv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (slot_valid),
        .i_item    (slot_item),
        .i_count   (slot_count),
        .o_valid   (out_valid),
        .o_item    (out_item),
        .o_degrees (out_degrees)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {3'b000, out_degrees, out_item.current, out_item.speed,
                            out_item.angle};
    assign m_axis_tuser  = {out_item.slot, out_item.matched};

endmodule

`default_nettype wire
